[rtl/core/i2cmbs_pkg.sv]
package i2cmbs_pkg;

  // Command codes carried by the opcode field.
  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_START = 2'd0;
  localparam opcode_t OP_STOP  = 2'd1;
  localparam opcode_t OP_WRITE = 2'd2;
  localparam opcode_t OP_READ  = 2'd3;

  // Tick counter: zero is idle, otherwise the index of the next tick plus one.
  localparam int PhaseW = 5;
  typedef logic [PhaseW-1:0] phase_t;

  // Tick indexes that mark the end of the data bits and the ack slot.
  localparam phase_t LastBitTick = 5'd16;
  localparam phase_t AckDrvTick  = 5'd17;
  localparam phase_t AckClkTick  = 5'd18;
  localparam phase_t MaxPhase    = 5'd20;

  // Pin state: SCL level, SDA drive enable, SDA level.
  typedef struct packed {
    logic scl;
    logic drv;
    logic sda;
  } pins_t;

endpackage

[rtl/core/i2c_master_byte_sequencer_top.sv]
// I2C master bit-level sequencer.
// Each transaction on the input channel is one timing tick of the I2C bus.
// While idle, a tick with cmd_valid set starts a command (start, stop,
// write byte with ack sample, read byte with ack drive), and that tick is
// already the first of its pin sequence. Commands that arrive while busy
// are ignored. Start and stop take 3 ticks, a write 20 and a read 19.
// Every input transaction yields exactly one output transaction holding the
// pin levels for that tick, busy and done flags, the last read byte and the
// last sampled acknowledge.
// The tick is evaluated between the state registers and the output register,
// so a result shows the cycle after its tick; one tick per cycle unless stalled.
// The output register stays loaded while out_stall is high; a new tick is
// taken in that case only once the waiting result has left, so in_stall
// follows out_valid and out_stall.
// Reset empties the output register, returns the sequencer to idle, and
// sets SCL high with SDA driven high.
module i2c_master_byte_sequencer_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd_valid,
  input  i2cmbs_pkg::opcode_t  opcode,
  input  logic [7:0]           tx_byte,
  input  logic                 ack_level,
  input  logic                 sda_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 scl_level,
  output logic                 sda_drive,
  output logic                 sda_level,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [7:0]           rx_byte,
  output logic                 ack_seen
);
  import i2cmbs_pkg::*;

  // Sequencer state.
  opcode_t    cmd;
  phase_t     phase;
  logic [7:0] shreg;
  logic       ack_tx;
  logic       ack_cap;
  pins_t      pins;
  logic [7:0] rx_hold;

  opcode_t    cmd_next;
  phase_t     phase_next;
  logic [7:0] shreg_next;
  logic       ack_tx_next;
  logic       ack_cap_next;
  pins_t      pins_next;
  logic [7:0] rx_hold_next;

  // Tick evaluation results.
  pins_t      emit;
  logic       busy_c;
  logic       last_c;
  phase_t     tick;
  logic [2:0] bit_idx;
  logic       in_fire;

  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // Evaluate one tick of the active command.
  always_comb begin
    cmd_next     = cmd;
    phase_next   = phase;
    shreg_next   = shreg;
    ack_tx_next  = ack_tx;
    ack_cap_next = ack_cap;
    pins_next    = pins;
    rx_hold_next = rx_hold;
    last_c       = 1'b0;

    // A command is taken only while idle.
    if (phase == '0 && cmd_valid) begin
      cmd_next    = opcode;
      shreg_next  = (opcode == OP_WRITE) ? tx_byte : 8'h00;
      ack_tx_next = ack_level;
      phase_next  = phase_t'(1);
    end

    busy_c  = (phase_next != '0);
    tick    = phase_next - phase_t'(1);
    bit_idx = ~tick[3:1];
    emit    = pins_next;

    if (busy_c) begin
      unique case (cmd_next)
        OP_START: begin
          if (tick == phase_t'(0)) begin
            pins_next = '{scl: 1'b1, drv: 1'b1, sda: 1'b1};
          end else if (tick == phase_t'(1)) begin
            pins_next.sda = 1'b0;
          end else begin
            pins_next.scl = 1'b0;
          end
          emit = pins_next;
          if (tick >= phase_t'(2)) begin
            pins_next.sda = 1'b1;
            last_c        = 1'b1;
          end
        end
        OP_STOP: begin
          if (tick == phase_t'(0)) begin
            pins_next.drv = 1'b1;
            pins_next.sda = 1'b0;
          end else if (tick == phase_t'(1)) begin
            pins_next.scl = 1'b1;
          end else begin
            pins_next.sda = 1'b1;
          end
          emit   = pins_next;
          last_c = (tick >= phase_t'(2));
        end
        OP_WRITE: begin
          if (tick == phase_t'(0)) begin
            pins_next.drv = 1'b1;
            emit          = pins_next;
          end else if (tick <= LastBitTick) begin
            if (tick[0]) begin
              // Data setup: present the next bit, MSB first.
              pins_next.sda = shreg_next[bit_idx];
              emit          = pins_next;
            end else begin
              // Clock pulse; SCL falls after this tick.
              pins_next.scl = 1'b1;
              emit          = pins_next;
              pins_next.scl = 1'b0;
            end
          end else if (tick == AckDrvTick) begin
            pins_next.drv = 1'b0;
            emit          = pins_next;
          end else if (tick == AckClkTick) begin
            pins_next.scl = 1'b1;
            emit          = pins_next;
            ack_cap_next  = sda_in;
            pins_next.scl = 1'b0;
          end else begin
            emit   = pins_next;
            last_c = 1'b1;
          end
        end
        OP_READ: begin
          if (tick == phase_t'(0)) begin
            pins_next.drv = 1'b0;
            emit          = pins_next;
          end else if (tick <= LastBitTick) begin
            if (tick[0]) begin
              // Clock high: sample the data bit.
              pins_next.scl = 1'b1;
              emit          = pins_next;
              shreg_next    = {shreg_next[6:0], sda_in};
              pins_next.scl = 1'b0;
            end else begin
              emit = pins_next;
            end
          end else if (tick == AckDrvTick) begin
            pins_next = '{scl: 1'b0, drv: 1'b1, sda: ack_tx_next};
            emit      = pins_next;
          end else begin
            pins_next.scl = 1'b1;
            emit          = pins_next;
            pins_next.scl = 1'b0;
            rx_hold_next  = shreg_next;
            last_c        = 1'b1;
          end
        end
        default: begin
          emit = pins_next;
        end
      endcase
      phase_next = last_c ? '0 : phase_next + phase_t'(1);
    end
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd     <= OP_START;
      phase   <= '0;
      shreg   <= 8'h00;
      ack_tx  <= 1'b0;
      ack_cap <= 1'b0;
      pins    <= '{scl: 1'b1, drv: 1'b1, sda: 1'b1};
      rx_hold <= 8'h00;
    end else if (in_fire) begin
      cmd     <= cmd_next;
      phase   <= phase_next;
      shreg   <= shreg_next;
      ack_tx  <= ack_tx_next;
      ack_cap <= ack_cap_next;
      pins    <= pins_next;
      rx_hold <= rx_hold_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scl_level <= emit.scl;
      sda_drive <= emit.drv;
      sda_level <= emit.drv & emit.sda;
      busy_res  <= busy_c;
      done_res  <= last_c;
      rx_byte   <= rx_hold_next;
      ack_seen  <= ack_cap_next;
    end
  end

  // The tick counter never runs past the longest sequence.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= MaxPhase)
    else $error("tick counter out of range");

  // A finishing tick leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_c |=> phase == '0)
    else $error("sequencer not idle after done");

  // A reported done always belongs to a busy tick.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res)
    else $error("done without busy");

  // A result held under stall blocks the input side.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(busy_res) && $stable(rx_byte))
    else $error("stalled result lost");

endmodule
